[src/nq_pkg.sv]
// Shared types and constants for the N-queens enumerator.
`timescale 1ns / 1ps

package nq_pkg;

   // Width of the board size register and of the result index fields
   localparam int FIELD_W = 5;

   // Board size after reset
   localparam logic [FIELD_W-1:0] BOARD_RESET = 5'd8;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_START,
      OP_LOAD,
      OP_CHECK,
      OP_BACK,
      OP_EMIT,
      OP_FINISH,
      OP_EXHAUST
   } dp_op_type;

   // Datapath status returned to the controller
   typedef struct packed {
      logic exhausted;   // no further solutions exist
      logic col_over;    // candidate column is past the board edge
      logic chk_done;    // every earlier row has been compared
      logic conflict;    // compared row shares a column or diagonal
      logic row_zero;    // backtracked above the first row
      logic row_is_n;    // current row is the last row of the board
      logic emit_last;   // next result row is the last one
      logic out_free;    // result register can take a new item
   } dp_status_type;

endpackage

[src/nq_datapath.sv]
// Placement store, conflict check and result register of the N-queens enumerator.
`timescale 1ns / 1ps

module nq_datapath #(
   parameter int MAX_SIZE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nq_pkg::dp_op_type           op,
   output nq_pkg::dp_status_type       status,
   input  logic                        csr_wr_en,
   input  logic [nq_pkg::FIELD_W-1:0]  csr_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nq_pkg::FIELD_W-1:0]  rsp_row_index,
   output logic [nq_pkg::FIELD_W-1:0]  rsp_column_index,
   output logic                        rsp_found,
   output logic                        rsp_last
);
   import nq_pkg::*;

   // Rows, columns and counters hold 0 .. MAX_SIZE + 1
   localparam int VW = $clog2(MAX_SIZE + 2);
   // Row store is indexed 1 .. MAX_SIZE, entry 0 unused
   localparam int QD = MAX_SIZE + 1;
   localparam int AW = $clog2(QD);
   localparam logic [VW-1:0] ONE   = VW'(1);
   localparam logic [VW-1:0] MAX_V = VW'(MAX_SIZE);

   logic [FIELD_W-1:0] board_ff, board_in;
   logic [VW-1:0]      queen_ff [QD];
   logic [VW-1:0]      cur_row_ff, cur_row_in;
   logic               exh_ff, exh_in;
   logic [VW-1:0]      row_ff, row_in;
   logic [VW-1:0]      col_ff, col_in;
   logic [VW-1:0]      chk_ff, chk_in;
   logic [VW-1:0]      k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [FIELD_W-1:0] rsp_col_ff, rsp_col_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [VW-1:0]      n_use;
   logic [VW-1:0]      start_row;
   logic [VW-1:0]      rd_addr;
   logic [VW-1:0]      rd_data;
   logic [VW-1:0]      dr;
   logic [VW-1:0]      dc;
   logic               col_over;
   logic               chk_done;
   logic               conflict;
   logic               q_we;
   logic [VW-1:0]      q_wa;
   logic [VW-1:0]      q_wd;
   logic               clear_all;
   logic               load_out;

   // Clamp the board size into 1 .. MAX_SIZE
   always_comb begin
      if (board_ff == '0) begin
         n_use = ONE;
      end else if (int'(board_ff) > MAX_SIZE) begin
         n_use = MAX_V;
      end else begin
         n_use = VW'(board_ff);
      end
   end

   // Resume row, kept inside the board
   always_comb begin
      if (cur_row_ff < ONE) begin
         start_row = ONE;
      end else if (cur_row_ff > n_use) begin
         start_row = n_use;
      end else begin
         start_row = cur_row_ff;
      end
   end

   // Select the one read address of the row store
   always_comb begin
      case (op)
         OP_CHECK:  rd_addr = chk_ff;
         OP_EMIT:   rd_addr = k_ff;
         OP_FINISH: rd_addr = n_use;
         default:   rd_addr = row_ff;
      endcase
   end

   assign rd_data = queen_ff[rd_addr[AW-1:0]];

   // Compare the candidate against one earlier row
   assign col_over = col_ff > n_use;
   assign chk_done = chk_ff == row_ff;
   assign dr       = row_ff - chk_ff;
   assign dc       = (col_ff > rd_data) ? (col_ff - rd_data) : (rd_data - col_ff);
   assign conflict = (rd_data == col_ff) || (dc == dr);

   // Next-state logic of the search registers
   always_comb begin
      board_in     = board_ff;
      cur_row_in   = cur_row_ff;
      exh_in       = exh_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      chk_in       = chk_ff;
      k_in         = k_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      q_we         = 1'b0;
      q_wa         = row_ff;
      q_wd         = ONE;
      clear_all    = 1'b0;
      load_out     = 1'b0;

      case (op)
         OP_CLEAR: begin
            clear_all = 1'b1;
         end
         OP_START: begin
            row_in = start_row;
            k_in   = ONE;
         end
         OP_LOAD: begin
            col_in = rd_data;
            chk_in = ONE;
         end
         OP_CHECK: begin
            if (col_over) begin
               // no column left: reset this row and step back
               q_we   = 1'b1;
               q_wd   = ONE;
               row_in = row_ff - ONE;
            end else if (chk_done) begin
               // place the queen and advance
               q_we   = 1'b1;
               q_wd   = col_ff;
               row_in = row_ff + ONE;
            end else if (conflict) begin
               col_in = col_ff + ONE;
               chk_in = ONE;
            end else begin
               chk_in = chk_ff + ONE;
            end
         end
         OP_BACK: begin
            col_in = rd_data + ONE;
            chk_in = ONE;
         end
         OP_EMIT: begin
            load_out     = 1'b1;
            rsp_row_in   = FIELD_W'(k_ff);
            rsp_col_in   = FIELD_W'(rd_data);
            rsp_found_in = 1'b1;
            rsp_last_in  = k_ff == n_use;
            k_in         = k_ff + ONE;
         end
         OP_FINISH: begin
            // move the last queen one column right for the next request
            q_we       = 1'b1;
            q_wa       = n_use;
            q_wd       = rd_data + ONE;
            cur_row_in = n_use;
         end
         OP_EXHAUST: begin
            load_out     = 1'b1;
            rsp_row_in   = '0;
            rsp_col_in   = '0;
            rsp_found_in = 1'b0;
            rsp_last_in  = 1'b1;
            exh_in       = 1'b1;
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         board_in  = csr_wr_data;
         clear_all = 1'b1;
      end

      if (clear_all) begin
         cur_row_in = ONE;
         exh_in     = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff     <= BOARD_RESET;
         cur_row_ff   <= ONE;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         board_ff     <= board_in;
         cur_row_ff   <= cur_row_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Row store: all columns back to one on reset, restart or size write
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < QD; i++) begin
            queen_ff[i] <= ONE;
         end
      end else if (q_we) begin
         queen_ff[q_wa[AW-1:0]] <= q_wd;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      chk_ff       <= chk_in;
      k_ff         <= k_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Report status
   always_comb begin
      status.exhausted = exh_ff;
      status.col_over  = col_over;
      status.chk_done  = chk_done;
      status.conflict  = conflict;
      status.row_zero  = row_ff == '0;
      status.row_is_n  = row_ff == n_use;
      status.emit_last = k_ff == n_use;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[src/nq_ctrl.sv]
// Search controller state machine of the N-queens enumerator.
`timescale 1ns / 1ps

module nq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart,
   input  nq_pkg::dp_status_type status,
   output nq_pkg::dp_op_type     op
);
   import nq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_START   = 8'b0000_0010,
      S_LOAD    = 8'b0000_0100,
      S_CHECK   = 8'b0000_1000,
      S_BACK    = 8'b0001_0000,
      S_EMIT    = 8'b0010_0000,
      S_FINISH  = 8'b0100_0000,
      S_EXHAUST = 8'b1000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // Take a request only when no search is running
   assign req_stall = state_ff != S_IDLE;

   // Sequence the search
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = req_restart ? OP_CLEAR : OP_NONE;
               state_in = S_START;
            end
         end
         S_START: begin
            op       = OP_START;
            state_in = status.exhausted ? S_EXHAUST : S_LOAD;
         end
         S_LOAD: begin
            op       = OP_LOAD;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            op = OP_CHECK;
            if (status.col_over) begin
               state_in = S_BACK;
            end else if (status.chk_done) begin
               state_in = status.row_is_n ? S_EMIT : S_LOAD;
            end
         end
         S_BACK: begin
            // advance the row above, or give up above the first row
            if (status.row_zero) begin
               state_in = S_EXHAUST;
            end else begin
               op       = OP_BACK;
               state_in = S_CHECK;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               op = OP_EMIT;
               if (status.emit_last) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            op       = OP_FINISH;
            state_in = S_IDLE;
         end
         S_EXHAUST: begin
            if (status.out_free) begin
               op       = OP_EXHAUST;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/n_queens_solution_enumerator.sv]
// Top level of the N-queens enumerator: controller, datapath and checks.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_restart
//   rsp      out  rsp_valid/rsp_stall  rsp_row_index, rsp_column_index, rsp_found, rsp_last
//   csr      in   csr_wr_en            csr_wr_data (board size)
//
// A request passes a start step, then compares each candidate column against the earlier
// rows one at a time, loads each new row before placing it and steps back a row when no
// column is left; it then emits the solution rows and finishes. The exhausted result
// follows once the search gives up. Run length depends on board size and position.
// Reset is synchronous; the board size returns to 8 and the search to its start.
// A stalled result holds in the output register; the search waits on it only to emit.
`timescale 1ns / 1ps

module n_queens_solution_enumerator #(
   parameter int MAX_SIZE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nq_pkg::FIELD_W-1:0]  rsp_row_index,
   output logic [nq_pkg::FIELD_W-1:0]  rsp_column_index,
   output logic                        rsp_found,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [nq_pkg::FIELD_W-1:0]  csr_wr_data
);
   import nq_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   nq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .status      (status),
      .op          (op)
   );

   nq_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

   // A solution row always names a real row and column
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_row_index != '0 && rsp_column_index != '0)
      else $error("solution row with zero index");

   // The exhausted result is a single, final, all-zero item
   a_exhausted_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_row_index == '0 &&
                                  rsp_column_index == '0)
      else $error("malformed exhausted result");

   // An accepted request keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a search could still start");

   // Row numbers of a solution count up by one until the last row
   a_row_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_found && !rsp_last |=>
         !rsp_valid || (rsp_found && rsp_row_index == $past(rsp_row_index) + 5'd1))
      else $error("solution rows out of order");

endmodule
